// ===== design/content_cache_lru_expiry_macros.svh =====
// assertion macros for the content cache
`ifndef CONTENT_CACHE_LRU_EXPIRY_MACROS_SVH
`define CONTENT_CACHE_LRU_EXPIRY_MACROS_SVH
`ifndef SYNTH
`define CCLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);
`define CCLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define CCLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define CCLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/ccle_pkg.sv =====
// types and codes of the content cache
`default_nettype none
package ccle_pkg;
	localparam logic [1:0] OP_PUT    = 2'd0;
	localparam logic [1:0] OP_MATCH  = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [2:0] S_STORED     = 3'd0;
	localparam logic [2:0] S_REF_EXP    = 3'd1;
	localparam logic [2:0] S_REF_CAP    = 3'd2;
	localparam logic [2:0] S_HIT        = 3'd3;
	localparam logic [2:0] S_MISS       = 3'd4;
	localparam logic [2:0] S_REMOVED    = 3'd5;
	localparam logic [2:0] S_NOT_FOUND  = 3'd6;

	localparam logic [1:0] C_NONE   = 2'd0;
	localparam logic [1:0] C_EXPIRY = 2'd1;
	localparam logic [1:0] C_LRU    = 2'd2;
	localparam logic [1:0] C_LOOKUP = 2'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_UPDATE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic purge;
		logic evict;
		logic ins;
		logic touch;
	} upd_t;
endpackage
`default_nettype wire

// ===== design/ccle_ifs.sv =====
// handshake channels of the content cache
`default_nettype none
interface ccle_in_if #(parameter int HANDLE_BITS = 16);
	logic                   valid;
	logic                   ready;
	logic [1:0]             op;
	logic [63:0]            name_key;
	logic [HANDLE_BITS-1:0] content_handle;
	logic                   has_expiry;
	logic [63:0]            expiry_ticks;
	logic [63:0]            now_ticks;
	modport source (output valid, op, name_key, content_handle, has_expiry,
		expiry_ticks, now_ticks, input ready);
	modport sink (input valid, op, name_key, content_handle, has_expiry,
		expiry_ticks, now_ticks, output ready);
endinterface

interface ccle_out_if #(parameter int HANDLE_BITS = 16);
	logic                   valid;
	logic                   ready;
	logic [2:0]             status;
	logic [HANDLE_BITS-1:0] hit_handle;
	logic                   replaced_valid;
	logic [HANDLE_BITS-1:0] replaced_handle;
	logic [1:0]             evict_cause;
	logic [HANDLE_BITS-1:0] evicted_handle;
	logic [6:0]             entry_count;
	modport source (output valid, status, hit_handle, replaced_valid, replaced_handle,
		evict_cause, evicted_handle, entry_count, input ready);
	modport sink (input valid, status, hit_handle, replaced_valid, replaced_handle,
		evict_cause, evicted_handle, entry_count, output ready);
endinterface

interface ccle_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== design/ccle_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module ccle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== design/content_cache_lru_expiry.sv =====
// content cache with lru replacement and expiry eviction, top level
// All entry state lives in one ram word per slot (valid, key, handle, expiry, recency rank).
// After reset a clearing pass invalidates every slot; no item is taken then.
// Each item takes a scan over the ram port (key lookup, free slot, oldest expiry and lru
// search), a decide step, and, when anything changes, a read-modify-write pass over every
// slot. The next item is taken while the last result waits on the output register.
`default_nettype none
`include "content_cache_lru_expiry_macros.svh"
module content_cache_lru_expiry #(
	parameter int SLOTS       = 64,
	parameter int HANDLE_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	ccle_in_if.sink   in_ch,
	ccle_out_if.source out_ch,
	ccle_cfg_if.sink  cfg
);
	localparam int AW   = $clog2(SLOTS);
	localparam int CW   = $clog2(SLOTS + 1);
	localparam int EW   = (CW > 7) ? CW : 7;
	localparam int HB   = HANDLE_BITS;
	localparam int R_LO = 2;
	localparam int H_LO = R_LO + AW;
	localparam int K_LO = H_LO + HB;
	localparam int X_LO = K_LO + 64;
	localparam int WW   = X_LO + 64;

	ccle_pkg::state_t state_q, state_d;

	logic [AW:0]    cnt_q;
	logic           rv_s1;
	logic [AW-1:0]  ridx_s1;
	logic [CW-1:0]  held_q;
	logic [6:0]     cap_q;

	logic [1:0]     op_q;
	logic [63:0]    key_q, exp_q, now_q;
	logic [HB-1:0]  hnd_q;
	logic           hx_q;

	logic           m_found_q, f_found_q, o_found_q, l_found_q;
	logic [AW-1:0]  m_idx_q, f_idx_q, o_idx_q, l_idx_q;
	logic [AW-1:0]  m_rank_q, o_rank_q, l_rank_q;
	logic [HB-1:0]  m_hnd_q, o_hnd_q, l_hnd_q;
	logic           m_hx_q;
	logic [63:0]    m_exp_q, o_exp_q;

	ccle_pkg::upd_t upd_q, upd_d;
	logic [AW-1:0]  p_idx_q, e_idx_q, n_idx_q, p_idx_d, e_idx_d, n_idx_d;
	logic [AW-1:0]  p_rank_q, e_rank_q, p_rank_d, e_rank_d;

	logic [2:0]     r_status_q, r_status_d;
	logic [HB-1:0]  r_hit_q, r_rep_q, r_evh_q, r_hit_d, r_rep_d, r_evh_d;
	logic           r_repv_q, r_repv_d;
	logic [1:0]     r_cause_q, r_cause_d;
	logic [CW-1:0]  held_d;

	logic           out_valid_q;
	logic [2:0]     o_status_q;
	logic [HB-1:0]  o_hit_q, o_rep_q, o_evh_q;
	logic           o_repv_q;
	logic [1:0]     o_cause_q;
	logic [6:0]     o_count_q;

	logic           ram_we, ram_re;
	logic [AW-1:0]  ram_waddr, ram_raddr;
	logic [WW-1:0]  ram_wdata, ram_rdata, upd_word;

	logic           in_fire, out_free, cnt_live, last_s1;

	logic           d_valid, d_hx;
	logic [AW-1:0]  d_rank;
	logic [HB-1:0]  d_hnd;
	logic [63:0]    d_key, d_exp;

	ccle_ram #(.WIDTH(WW), .DEPTH(SLOTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign d_valid = ram_rdata[0];
	assign d_hx    = ram_rdata[1];
	assign d_rank  = ram_rdata[R_LO +: AW];
	assign d_hnd   = ram_rdata[H_LO +: HB];
	assign d_key   = ram_rdata[K_LO +: 64];
	assign d_exp   = ram_rdata[X_LO +: 64];

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign cnt_live = cnt_q < (AW+1)'(SLOTS);
	assign last_s1  = rv_s1 && (ridx_s1 == AW'(SLOTS - 1));
	assign cfg.ready = 1'b1;

	// per-slot rewrite during the update pass
	always_comb begin
		logic [AW-1:0] x;
		logic          v;
		x = d_rank;
		v = d_valid;
		if (upd_q.purge) begin
			if (ridx_s1 == p_idx_q) v = 1'b0;
			else if (x > p_rank_q) x = x - AW'(1);
		end
		if (upd_q.evict) begin
			if (ridx_s1 == e_idx_q) v = 1'b0;
			else if (x > e_rank_q) x = x - AW'(1);
		end
		if (upd_q.ins) begin
			x = x + AW'(1);
		end
		if (upd_q.touch) begin
			if (ridx_s1 == p_idx_q) x = '0;
			else if (x < p_rank_q) x = x + AW'(1);
		end
		upd_word = ram_rdata;
		upd_word[0] = v;
		upd_word[R_LO +: AW] = x;
		if (upd_q.ins && ridx_s1 == n_idx_q) begin
			upd_word[0] = 1'b1;
			upd_word[1] = hx_q;
			upd_word[R_LO +: AW] = '0;
			upd_word[H_LO +: HB] = hnd_q;
			upd_word[K_LO +: 64] = key_q;
			upd_word[X_LO +: 64] = hx_q ? exp_q : 64'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccle_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ch.ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = ridx_s1;
		ram_wdata = upd_word;
		ram_re    = 1'b0;
		ram_raddr = cnt_q[AW-1:0];
		unique case (state_q)
			ccle_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q[AW-1:0];
				ram_wdata = '0;
				if (cnt_q[AW-1:0] == AW'(SLOTS - 1)) state_d = ccle_pkg::ST_IDLE;
			end
			ccle_pkg::ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_fire) state_d = ccle_pkg::ST_SCAN;
			end
			ccle_pkg::ST_SCAN: begin
				ram_re = cnt_live;
				if (last_s1) state_d = ccle_pkg::ST_DECIDE;
			end
			ccle_pkg::ST_DECIDE: begin
				state_d = (upd_d != '0) ? ccle_pkg::ST_UPDATE : ccle_pkg::ST_DONE;
			end
			ccle_pkg::ST_UPDATE: begin
				ram_re = cnt_live;
				ram_we = rv_s1;
				if (last_s1) state_d = ccle_pkg::ST_DONE;
			end
			ccle_pkg::ST_DONE: begin
				if (out_free) state_d = ccle_pkg::ST_IDLE;
			end
			default: state_d = ccle_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			rv_s1   <= 1'b0;
			cap_q   <= 7'd64;
			held_q  <= '0;
		end else begin
			if (state_q == ccle_pkg::ST_IDLE || state_q == ccle_pkg::ST_DECIDE) begin
				cnt_q <= '0;
			end else if (state_q == ccle_pkg::ST_CLEAR || cnt_live) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end
			rv_s1 <= (state_q == ccle_pkg::ST_SCAN || state_q == ccle_pkg::ST_UPDATE) && cnt_live;
			if (cfg.valid && cfg.ready) cap_q <= cfg.data;
			if (state_q == ccle_pkg::ST_DECIDE) held_q <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= cnt_q[AW-1:0];
		if (in_fire) begin
			op_q  <= in_ch.op;
			key_q <= in_ch.name_key;
			hnd_q <= in_ch.content_handle;
			hx_q  <= in_ch.has_expiry;
			exp_q <= in_ch.expiry_ticks;
			now_q <= in_ch.now_ticks;
			m_found_q <= 1'b0;
			f_found_q <= 1'b0;
			o_found_q <= 1'b0;
			l_found_q <= 1'b0;
		end else if (state_q == ccle_pkg::ST_SCAN && rv_s1) begin
			if (!d_valid) begin
				if (!f_found_q) begin
					f_found_q <= 1'b1;
					f_idx_q   <= ridx_s1;
				end
			end else if (d_key == key_q) begin
				if (!m_found_q) begin
					m_found_q <= 1'b1;
					m_idx_q   <= ridx_s1;
					m_rank_q  <= d_rank;
					m_hnd_q   <= d_hnd;
					m_hx_q    <= d_hx;
					m_exp_q   <= d_exp;
				end
			end else begin
				if (d_hx && (!o_found_q || d_exp < o_exp_q)) begin
					o_found_q <= 1'b1;
					o_idx_q   <= ridx_s1;
					o_exp_q   <= d_exp;
					o_rank_q  <= d_rank;
					o_hnd_q   <= d_hnd;
				end
				if (!l_found_q || d_rank > l_rank_q) begin
					l_found_q <= 1'b1;
					l_idx_q   <= ridx_s1;
					l_rank_q  <= d_rank;
					l_hnd_q   <= d_hnd;
				end
			end
		end
		if (state_q == ccle_pkg::ST_DECIDE) begin
			upd_q      <= upd_d;
			p_idx_q    <= p_idx_d;
			p_rank_q   <= p_rank_d;
			e_idx_q    <= e_idx_d;
			e_rank_q   <= e_rank_d;
			n_idx_q    <= n_idx_d;
			r_status_q <= r_status_d;
			r_hit_q    <= r_hit_d;
			r_repv_q   <= r_repv_d;
			r_rep_q    <= r_rep_d;
			r_cause_q  <= r_cause_d;
			r_evh_q    <= r_evh_d;
		end
	end

	// decision for the item from the scan results
	always_comb begin
		logic [EW-1:0] cap_e, cnt1;
		logic          have_free;
		logic [AW-1:0] free_idx;
		upd_d      = '0;
		p_idx_d    = m_idx_q;
		p_rank_d   = m_rank_q;
		e_idx_d    = l_idx_q;
		e_rank_d   = l_rank_q;
		n_idx_d    = f_idx_q;
		r_status_d = ccle_pkg::S_NOT_FOUND;
		r_hit_d    = '0;
		r_repv_d   = 1'b0;
		r_rep_d    = '0;
		r_cause_d  = ccle_pkg::C_NONE;
		r_evh_d    = '0;
		held_d     = held_q;
		cap_e = (EW'(cap_q) > EW'(SLOTS)) ? EW'(SLOTS) : EW'(cap_q);
		cnt1  = EW'(held_q) - EW'(m_found_q);
		have_free = f_found_q;
		free_idx  = f_idx_q;
		unique case (op_q)
			ccle_pkg::OP_PUT: begin
				if (cap_e == '0) begin
					r_status_d = ccle_pkg::S_REF_CAP;
				end else begin
					if (m_found_q) begin
						upd_d.purge = 1'b1;
						r_repv_d = 1'b1;
						r_rep_d  = m_hnd_q;
						held_d   = CW'(cnt1);
						if (!have_free || m_idx_q < free_idx) free_idx = m_idx_q;
						have_free = 1'b1;
					end
					if (hx_q && now_q >= exp_q) begin
						r_status_d = ccle_pkg::S_REF_EXP;
					end else begin
						if (cnt1 >= cap_e) begin
							if (o_found_q && o_exp_q < now_q) begin
								upd_d.evict = 1'b1;
								e_idx_d   = o_idx_q;
								e_rank_d  = o_rank_q;
								r_cause_d = ccle_pkg::C_EXPIRY;
								r_evh_d   = o_hnd_q;
							end else if (l_found_q) begin
								upd_d.evict = 1'b1;
								r_cause_d = ccle_pkg::C_LRU;
								r_evh_d   = l_hnd_q;
							end
							if (m_found_q && e_rank_d > m_rank_q) e_rank_d = e_rank_d - AW'(1);
							if (upd_d.evict) begin
								if (!have_free || e_idx_d < free_idx) free_idx = e_idx_d;
								have_free = 1'b1;
							end
						end
						if (have_free) begin
							upd_d.ins  = 1'b1;
							n_idx_d    = free_idx;
							r_status_d = ccle_pkg::S_STORED;
							held_d     = CW'(cnt1 - EW'(upd_d.evict) + EW'(1));
						end else begin
							r_status_d = ccle_pkg::S_REF_CAP;
							held_d     = CW'(cnt1 - EW'(upd_d.evict));
						end
					end
				end
			end
			ccle_pkg::OP_MATCH: begin
				r_status_d = ccle_pkg::S_MISS;
				if (m_found_q) begin
					if (m_hx_q && m_exp_q < now_q) begin
						upd_d.purge = 1'b1;
						r_cause_d   = ccle_pkg::C_LOOKUP;
						r_evh_d     = m_hnd_q;
						held_d      = CW'(cnt1);
					end else begin
						upd_d.touch = 1'b1;
						r_status_d  = ccle_pkg::S_HIT;
						r_hit_d     = m_hnd_q;
					end
				end
			end
			ccle_pkg::OP_REMOVE: begin
				if (m_found_q) begin
					upd_d.purge = 1'b1;
					r_status_d  = ccle_pkg::S_REMOVED;
					r_repv_d    = 1'b1;
					r_rep_d     = m_hnd_q;
					held_d      = CW'(cnt1);
				end
			end
			default: r_status_d = ccle_pkg::S_NOT_FOUND;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ccle_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ccle_pkg::ST_DONE && out_free) begin
			o_status_q <= r_status_q;
			o_hit_q    <= r_hit_q;
			o_repv_q   <= r_repv_q;
			o_rep_q    <= r_rep_q;
			o_cause_q  <= r_cause_q;
			o_evh_q    <= r_evh_q;
			o_count_q  <= 7'(held_q);
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.status          = o_status_q;
	assign out_ch.hit_handle      = o_hit_q;
	assign out_ch.replaced_valid  = o_repv_q;
	assign out_ch.replaced_handle = o_rep_q;
	assign out_ch.evict_cause     = o_cause_q;
	assign out_ch.evicted_handle  = o_evh_q;
	assign out_ch.entry_count     = o_count_q;

	`CCLE_ASSERT_NOW(a_held_bound, clk, arst_n, 1'b1, held_q <= CW'(SLOTS), "held count above slots")
	`CCLE_ASSERT_NOW(a_touch_alone, clk, arst_n, state_q == ccle_pkg::ST_UPDATE && upd_q.touch, !upd_q.purge && !upd_q.evict && !upd_q.ins, "touch mixed with other updates")
	`CCLE_ASSERT_NOW(a_evict_ins, clk, arst_n, state_q == ccle_pkg::ST_UPDATE && upd_q.evict, upd_q.ins, "eviction without insert")
	`CCLE_ASSERT_NEXT(a_accept_scan, clk, arst_n, in_fire, state_q == ccle_pkg::ST_SCAN && cnt_q == '0, "accepted item does not start a scan")
endmodule
`default_nettype wire
